/* rtl/core/pir_pkg.sv */
// Package for the primitive index rewriter: word types, mode and register codes.
`default_nettype none

package pir_pkg;

    localparam int INDEX_BITS  = 32;
    localparam int BURST_MAX   = 8;
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [3:0] MODE_POINTS     = 4'd0;
    localparam logic [3:0] MODE_LINES      = 4'd1;
    localparam logic [3:0] MODE_LINE_STRIP = 4'd2;
    localparam logic [3:0] MODE_LINE_LOOP  = 4'd3;
    localparam logic [3:0] MODE_TRIS       = 4'd4;
    localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
    localparam logic [3:0] MODE_TRI_FAN    = 4'd6;
    localparam logic [3:0] MODE_QUADS      = 4'd7;
    localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;
    localparam logic [3:0] MODE_POLYGON    = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIM_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLYGON_LINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROVOKE_LAST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAT_SHADE   = 2'd3;

    typedef struct packed {
        logic [31:0] vertex_index;
        logic        batch_end;
    } t_in_word;

    typedef struct packed {
        logic [31:0] out_index;
        logic        run_last;
    } t_out_word;

    typedef struct packed {
        logic [3:0] prim_mode;
        logic       polygon_line;
        logic       provoke_last;
        logic       flat_shade;
    } t_cfg;

    typedef struct packed {
        logic [BURST_MAX-1:0][INDEX_BITS-1:0] idx;
        logic [BURST_CNT_W-1:0]               cnt;
    } t_burst;

endpackage

`default_nettype wire

/* rtl/core/pir_assemble.sv */
// Primitive state registers and the per-word rewrite into a burst of indices.
`default_nettype none

module pir_assemble (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pir_pkg::t_cfg     i_cfg,
    input  wire logic              i_take,
    input  wire pir_pkg::t_in_word i_word,
    output pir_pkg::t_burst        o_burst
);
    import pir_pkg::*;

    logic [INDEX_BITS-1:0] r_recent0, r_recent1, r_hub;
    logic [1:0]            r_seen;
    logic [2:0]            r_phase;
    logic                  r_parity;

    logic [INDEX_BITS-1:0] n_recent0, n_recent1, n_hub;
    logic [1:0]            n_seen;
    logic [2:0]            n_phase;
    logic                  n_parity;

    logic [INDEX_BITS-1:0] v, h, r0, r1;
    logic                  last, flat, pline, fin, pass;
    logic [BURST_MAX-1:0][INDEX_BITS-1:0] lst;
    logic [BURST_CNT_W-1:0]               cnt;

    assign v     = i_word.vertex_index[INDEX_BITS-1:0];
    assign fin   = i_word.batch_end;
    assign last  = i_cfg.provoke_last;
    assign flat  = i_cfg.flat_shade;
    assign pline = i_cfg.polygon_line;
    assign r0    = r_recent0;
    assign r1    = r_recent1;
    assign h     = (r_seen == 2'd0) ? v : r_hub;

    assign pass = (i_cfg.prim_mode == MODE_POINTS) || (i_cfg.prim_mode > MODE_POLYGON) ||
                  (((i_cfg.prim_mode == MODE_LINES) || (i_cfg.prim_mode == MODE_TRIS)) &&
                   !(last && flat));

    always_comb begin
        lst      = '0;
        cnt      = '0;
        n_hub    = h;
        n_phase  = r_phase;
        n_parity = r_parity;
        if (pass) begin
            lst[0] = v;
            cnt    = BURST_CNT_W'(1);
        end else begin
            case (i_cfg.prim_mode) inside
                MODE_LINES: begin
                    if (r_phase == 3'd1) begin
                        lst[0]  = last ? v : r1;
                        lst[1]  = last ? r1 : v;
                        cnt     = BURST_CNT_W'(2);
                        n_phase = 3'd0;
                    end else begin
                        n_phase = 3'd1;
                    end
                end
                MODE_LINE_STRIP, MODE_LINE_LOOP: begin
                    if (r_seen != 2'd0) begin
                        lst[0] = last ? v : r1;
                        lst[1] = last ? r1 : v;
                        cnt    = BURST_CNT_W'(2);
                        if ((i_cfg.prim_mode == MODE_LINE_LOOP) && fin) begin
                            lst[2] = last ? h : v;
                            lst[3] = last ? v : h;
                            cnt    = BURST_CNT_W'(4);
                        end
                    end
                end
                MODE_TRIS: begin
                    if (r_phase == 3'd2) begin
                        lst[0]  = last ? v : r0;
                        lst[1]  = last ? r0 : r1;
                        lst[2]  = last ? r1 : v;
                        cnt     = BURST_CNT_W'(3);
                        n_phase = 3'd0;
                    end else begin
                        // a phase carried past a whole primitive by a mode change stays put
                        n_phase = (r_phase == 3'd4) ? r_phase : r_phase + 3'd1;
                    end
                end
                MODE_TRI_STRIP: begin
                    if (r_seen >= 2'd2) begin
                        if (r_parity) begin
                            lst[0] = last ? v : r0;
                            lst[1] = last ? r1 : v;
                            lst[2] = last ? r0 : r1;
                        end else begin
                            lst[0] = last ? v : r0;
                            lst[1] = last ? r0 : r1;
                            lst[2] = last ? r1 : v;
                        end
                        cnt      = BURST_CNT_W'(3);
                        n_parity = ~r_parity;
                    end
                end
                MODE_TRI_FAN: begin
                    if (r_seen >= 2'd2) begin
                        lst[0] = last ? v : r1;
                        lst[1] = last ? h : v;
                        lst[2] = last ? r1 : h;
                        cnt    = BURST_CNT_W'(3);
                    end
                end
                MODE_QUADS: begin
                    if (r_phase == 3'd0) begin
                        n_hub = v;
                    end
                    if (r_phase == 3'd3) begin
                        if (pline) begin
                            lst = {h, v, v, r1, r1, r0, r0, h};
                            cnt = BURST_CNT_W'(8);
                        end else if (flat) begin
                            lst[0] = v;  lst[1] = h;  lst[2] = r0;
                            lst[3] = v;  lst[4] = r0; lst[5] = r1;
                            cnt    = BURST_CNT_W'(6);
                        end else begin
                            lst[0] = h;  lst[1] = r0; lst[2] = r1;
                            lst[3] = h;  lst[4] = r1; lst[5] = v;
                            cnt    = BURST_CNT_W'(6);
                        end
                        n_phase = 3'd0;
                    end else begin
                        n_phase = (r_phase == 3'd4) ? r_phase : r_phase + 3'd1;
                    end
                end
                MODE_QUAD_STRIP: begin
                    if (r_phase == 3'd1) begin
                        if (r_seen == 2'd3) begin
                            if (pline) begin
                                lst = {h, r1, r1, v, v, r0, r0, h};
                                cnt = BURST_CNT_W'(8);
                            end else if (flat) begin
                                lst[0] = v;  lst[1] = r1; lst[2] = h;
                                lst[3] = v;  lst[4] = h;  lst[5] = r0;
                                cnt    = BURST_CNT_W'(6);
                            end else begin
                                lst[0] = h;  lst[1] = r0; lst[2] = r1;
                                lst[3] = r1; lst[4] = r0; lst[5] = v;
                                cnt    = BURST_CNT_W'(6);
                            end
                        end
                        n_hub   = r1;
                        n_phase = 3'd0;
                    end else begin
                        n_phase = 3'd1;
                    end
                end
                default: begin
                    // polygon
                    if (pline) begin
                        if (r_seen != 2'd0) begin
                            lst[0] = r1;
                            lst[1] = v;
                            cnt    = BURST_CNT_W'(2);
                            if (fin) begin
                                lst[2] = v;
                                lst[3] = h;
                                cnt    = BURST_CNT_W'(4);
                            end
                        end
                    end else if (r_seen >= 2'd2) begin
                        lst[0] = h;
                        lst[1] = r1;
                        lst[2] = v;
                        cnt    = BURST_CNT_W'(3);
                    end
                end
            endcase
        end

        n_recent0 = r1;
        n_recent1 = v;
        n_seen    = (r_seen == 2'd3) ? r_seen : r_seen + 2'd1;
        if (fin) begin
            n_recent0 = '0;
            n_recent1 = '0;
            n_hub     = '0;
            n_seen    = '0;
            n_phase   = '0;
            n_parity  = 1'b0;
        end
    end

    assign o_burst.idx = lst;
    assign o_burst.cnt = cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent0 <= '0;
            r_recent1 <= '0;
            r_hub     <= '0;
            r_seen    <= '0;
            r_phase   <= '0;
            r_parity  <= 1'b0;
        end else if (i_take) begin
            r_recent0 <= n_recent0;
            r_recent1 <= n_recent1;
            r_hub     <= n_hub;
            r_seen    <= n_seen;
            r_phase   <= n_phase;
            r_parity  <= n_parity;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pir_drain.sv */
// Result register: holds one burst of indices and hands them out a word per cycle while the output is not stalled.
`default_nettype none

module pir_drain (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire pir_pkg::t_burst i_burst,
    input  wire logic            i_out_stall,
    output logic                 o_out_valid,
    output pir_pkg::t_out_word   o_out_word,
    output logic                 o_busy
);
    import pir_pkg::*;

    logic [BURST_MAX-1:0][INDEX_BITS-1:0] r_list;
    logic [BURST_CNT_W-1:0]               r_cnt;
    logic                                 take;

    assign o_out_valid         = (r_cnt != '0);
    assign take                = o_out_valid && !i_out_stall;
    assign o_out_word.out_index = 32'(r_list[0]);
    assign o_out_word.run_last  = (r_cnt == BURST_CNT_W'(1));
    // free for a new burst once the last pending word goes this cycle
    assign o_busy = (r_cnt > BURST_CNT_W'(1)) || ((r_cnt == BURST_CNT_W'(1)) && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - BURST_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_list <= i_burst.idx;
        end else if (take) begin
            for (int i = 0; i < BURST_MAX - 1; i++) begin
                r_list[i] <= r_list[i+1];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/primitive_index_rewriter.sv */
// Top level of the primitive index rewriter: configuration registers and the two stages.
// The first index of an item is registered and appears in the cycle after the item is accepted.
// An item gives from 0 to 8 indices; the result register hands out one index per cycle while
// the output is not stalled, and takes the next item's burst as it empties.
// Reset (synchronous, active low) clears the configuration, the primitive state
// and the result register.
`default_nettype none

module primitive_index_rewriter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire pir_pkg::t_in_word                   i_in_word,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output pir_pkg::t_out_word                       o_out_word,
    input  wire logic                                i_cfg_we,
    input  wire logic [pir_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [pir_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pir_pkg::*;

    t_cfg   r_cfg;
    t_burst burst;
    logic   take;
    logic   busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRIM_MODE:    r_cfg.prim_mode    <= i_cfg_data;
                CFG_POLYGON_LINE: r_cfg.polygon_line <= i_cfg_data[0];
                CFG_PROVOKE_LAST: r_cfg.provoke_last <= i_cfg_data[0];
                CFG_FLAT_SHADE:   r_cfg.flat_shade   <= i_cfg_data[0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_in_stall = busy;
    assign take       = i_in_valid && !busy;

    pir_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .i_word  (i_in_word),
        .o_burst (burst)
    );

    pir_drain u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_burst     (burst),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_busy      (busy)
    );

endmodule

`default_nettype wire

/* rtl/core/pir_checker.sv */
// Port-level checks for the primitive index rewriter, bound to the top level.
`default_nettype none

module pir_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire pir_pkg::t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid straight after reset");

    a_burst_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.run_last) |-> o_in_stall)
        else $error("input taken while a burst is still pending");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with nothing pending");

endmodule

bind primitive_index_rewriter pir_checker u_pir_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
